@@ design/v3a_pkg.sv @@
// ----------------------------------------------------------------------------
// v3a_pkg
// Types, operation codes and helpers shared by the vector ALU modules.
// ----------------------------------------------------------------------------
package v3a_pkg;

    typedef enum logic [2:0] {
        MODE_ADD   = 3'd0,
        MODE_SUB   = 3'd1,
        MODE_SCALE = 3'd2,
        MODE_CROSS = 3'd3,
        MODE_DOT   = 3'd4,
        MODE_NORM  = 3'd5
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] scale_factor;
    } in_t;

    typedef struct packed {
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic signed [31:0] dot_value;
        logic               overflow;
        logic               zero_length;
    } out_t;

    // Everything that rides alongside the square root and divide stages
    typedef struct packed {
        out_t              res;
        logic              is_norm;
        logic [2:0]        neg;
        logic [2:0][31:0]  mag;
    } norm_side_t;

    localparam logic signed [31:0] MAX32 = 32'sh7fff_ffff;
    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

    // Saturate a wide value to 32 bits; top bit of the result is the overflow flag
    function automatic logic [32:0] sat32(input logic signed [65:0] v);
        logic fits;
        fits = (v[65:31] == '0) || (v[65:31] == '1);
        if (fits) begin
            return {1'b0, v[31:0]};
        end
        return {1'b1, (v[65] ? MIN32 : MAX32)};
    endfunction

endpackage

@@ design/v3a_norm.sv @@
// ----------------------------------------------------------------------------
// v3a_norm
// Pipelined integer square root (one result bit per stage) followed by a
// three-lane restoring divider (one quotient bit per stage).
// ----------------------------------------------------------------------------
module v3a_norm #(
    parameter int FRAC_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [63:0]         in_sq,
    input  v3a_pkg::norm_side_t in_side,
    output logic                out_valid,
    output v3a_pkg::out_t       out_res
);
    import v3a_pkg::*;

    localparam int SQ_STAGES = 32;
    localparam int DV_STAGES = FRAC_BITS + 1;

    logic              sq_valid_reg [SQ_STAGES];
    logic [33:0]       sq_rem_reg   [SQ_STAGES];
    logic [31:0]       sq_root_reg  [SQ_STAGES];
    logic [63:0]       sq_n_reg     [SQ_STAGES];
    norm_side_t        sq_side_reg  [SQ_STAGES];

    logic                     dv_valid_reg [DV_STAGES];
    logic [2:0][31:0]         dv_rem_reg   [DV_STAGES];
    logic [2:0][FRAC_BITS:0]  dv_q_reg     [DV_STAGES];
    logic [31:0]              dv_m_reg     [DV_STAGES];
    norm_side_t               dv_side_reg  [DV_STAGES];

    // Square root: two radicand bits enter per stage
    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
        logic        v_in;
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] n_in;
        norm_side_t  side_in;
        logic [35:0] rem_sh;
        logic [35:0] trial;
        logic        ge;
        logic [33:0] rem_next;
        logic [31:0] root_next;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign n_in    = in_sq;
            assign side_in = in_side;
        end else begin : g_next
            assign v_in    = sq_valid_reg[k-1];
            assign rem_in  = sq_rem_reg[k-1];
            assign root_in = sq_root_reg[k-1];
            assign n_in    = sq_n_reg[k-1];
            assign side_in = sq_side_reg[k-1];
        end

        assign rem_sh    = {rem_in, n_in[63:62]};
        assign trial     = {2'b00, root_in, 2'b01};
        assign ge        = (rem_sh >= trial);
        assign rem_next  = ge ? 34'(rem_sh - trial) : rem_sh[33:0];
        assign root_next = {root_in[30:0], ge};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_valid_reg[k] <= 1'b0;
            end else if (en) begin
                sq_valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_rem_reg[k]  <= rem_next;
                sq_root_reg[k] <= root_next;
                sq_n_reg[k]    <= {n_in[61:0], 2'b00};
                sq_side_reg[k] <= side_in;
            end
        end
    end

    // Divide |b| * 2^FRAC_BITS by the root; |b| never exceeds the root
    for (genvar j = 0; j < DV_STAGES; j++) begin : g_dv
        logic                    v_in;
        logic [31:0]             m_in;
        norm_side_t              side_in;
        logic [2:0][32:0]        part;
        logic [2:0][31:0]        rem_next;
        logic [2:0][FRAC_BITS:0] q_next;
        logic [2:0][FRAC_BITS:0] q_in;

        if (j == 0) begin : g_first
            assign v_in    = sq_valid_reg[SQ_STAGES-1];
            assign m_in    = sq_root_reg[SQ_STAGES-1];
            assign side_in = sq_side_reg[SQ_STAGES-1];
            assign q_in    = '0;
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign part[l] = {1'b0, side_in.mag[l]};
            end
        end else begin : g_next
            assign v_in    = dv_valid_reg[j-1];
            assign m_in    = dv_m_reg[j-1];
            assign side_in = dv_side_reg[j-1];
            assign q_in    = dv_q_reg[j-1];
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign part[l] = {dv_rem_reg[j-1][l], 1'b0};
            end
        end

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                if (part[l] >= {1'b0, m_in}) begin
                    rem_next[l] = 32'(part[l] - {1'b0, m_in});
                    q_next[l]   = {q_in[l][FRAC_BITS-1:0], 1'b1};
                end else begin
                    rem_next[l] = part[l][31:0];
                    q_next[l]   = {q_in[l][FRAC_BITS-1:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[j] <= 1'b0;
            end else if (en) begin
                dv_valid_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_rem_reg[j]  <= rem_next;
                dv_q_reg[j]    <= q_next;
                dv_m_reg[j]    <= m_in;
                dv_side_reg[j] <= side_in;
            end
        end
    end

    // Apply signs and the zero-length case
    norm_side_t              last_side;
    logic [2:0][FRAC_BITS:0] last_q;
    logic [2:0][31:0]        lane_r;
    logic                    zero_len;

    assign last_side = dv_side_reg[DV_STAGES-1];
    assign last_q    = dv_q_reg[DV_STAGES-1];
    assign zero_len  = (dv_m_reg[DV_STAGES-1] == '0);
    assign out_valid = dv_valid_reg[DV_STAGES-1];

    always_comb begin
        logic [31:0] mq;
        for (int l = 0; l < 3; l++) begin
            mq        = {{(31-FRAC_BITS){1'b0}}, last_q[l]};
            lane_r[l] = (zero_len) ? '0 : (last_side.neg[l] ? 32'(-mq) : mq);
        end
        out_res = last_side.res;
        if (last_side.is_norm) begin
            out_res.r_x         = lane_r[0];
            out_res.r_y         = lane_r[1];
            out_res.r_z         = lane_r[2];
            out_res.zero_length = zero_len;
        end
    end

endmodule

@@ design/vec3_alu.sv @@
// ----------------------------------------------------------------------------
// vec3_alu
// Three-component Q-format vector ALU: add, subtract, scale, cross, dot and
// normalize, with saturation and flags.
// ----------------------------------------------------------------------------
// Fully pipelined: one word is accepted every cycle unless the output is
// stalled, and every word passes through the same stages from input to
// output register (three multiply/combine stages, 32 square root stages,
// FRAC_BITS + 1 divide stages, then the output register). The depth is set
// by the bit-serial square root and divide pipelines that serve normalize;
// all other operations travel alongside them so results leave in order. A
// stalled output holds the whole pipeline.
module vec3_alu #(
    parameter int FRAC_BITS = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  v3a_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output v3a_pkg::out_t  m_data
);
    import v3a_pkg::*;

    logic m_valid_reg;
    logic en;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // Stage A: multipliers and add/subtract
    logic signed [31:0] op_l [6];
    logic signed [31:0] op_r [6];

    logic                     a_valid_reg;
    mode_t                    a_mode_reg;
    logic signed [32:0]       a_sum_reg  [3];
    logic signed [63:0]       a_prod_reg [6];
    logic [2:0][31:0]         a_mag_reg;
    logic [2:0]               a_neg_reg;

    logic signed [32:0]       a_sum_next [3];
    logic [2:0][31:0]         a_mag_next;
    logic signed [31:0]       av [3];
    logic signed [31:0]       bv [3];

    assign av[0] = s_data.a_x;
    assign av[1] = s_data.a_y;
    assign av[2] = s_data.a_z;
    assign bv[0] = s_data.b_x;
    assign bv[1] = s_data.b_y;
    assign bv[2] = s_data.b_z;

    always_comb begin
        op_l[3] = av[2]; op_r[3] = bv[1];
        op_l[4] = av[0]; op_r[4] = bv[2];
        op_l[5] = av[1]; op_r[5] = bv[0];
        unique case (s_data.mode)
            MODE_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    op_l[i] = av[i];
                    op_r[i] = s_data.scale_factor;
                end
            end
            MODE_CROSS: begin
                op_l[0] = av[1]; op_r[0] = bv[2];
                op_l[1] = av[2]; op_r[1] = bv[0];
                op_l[2] = av[0]; op_r[2] = bv[1];
            end
            MODE_DOT: begin
                for (int i = 0; i < 3; i++) begin
                    op_l[i] = av[i];
                    op_r[i] = bv[i];
                end
            end
            default: begin
                for (int i = 0; i < 3; i++) begin
                    op_l[i] = bv[i];
                    op_r[i] = bv[i];
                end
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            a_sum_next[i] = (s_data.mode == MODE_SUB) ?
                (33'(av[i]) - 33'(bv[i])) : (33'(av[i]) + 33'(bv[i]));
            a_mag_next[i] = bv[i][31] ? 32'(-bv[i]) : bv[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_mode_reg <= s_data.mode;
            for (int i = 0; i < 3; i++) begin
                a_sum_reg[i] <= a_sum_next[i];
                a_neg_reg[i] <= bv[i][31];
            end
            for (int i = 0; i < 6; i++) begin
                a_prod_reg[i] <= op_l[i] * op_r[i];
            end
            a_mag_reg <= a_mag_next;
        end
    end

    // Stage B: line everything up at full width with 2 * FRAC_BITS fraction bits
    logic                     b_valid_reg;
    mode_t                    b_mode_reg;
    logic signed [65:0]       b_wide_reg [3];
    logic [63:0]              b_sq_reg;
    logic [2:0][31:0]         b_mag_reg;
    logic [2:0]               b_neg_reg;
    logic signed [65:0]       b_wide_next [3];
    logic signed [65:0]       pe [6];

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            pe[i] = 66'(a_prod_reg[i]);
        end
        for (int i = 0; i < 3; i++) begin
            b_wide_next[i] = '0;
        end
        unique case (a_mode_reg)
            MODE_ADD, MODE_SUB: begin
                for (int i = 0; i < 3; i++) begin
                    b_wide_next[i] = 66'(a_sum_reg[i]) <<< FRAC_BITS;
                end
            end
            MODE_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    b_wide_next[i] = pe[i];
                end
            end
            MODE_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    b_wide_next[i] = pe[i] - pe[i+3];
                end
            end
            MODE_DOT: begin
                b_wide_next[0] = pe[0] + pe[1] + pe[2];
            end
            default: begin
                for (int i = 0; i < 3; i++) begin
                    b_wide_next[i] = '0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_mode_reg <= a_mode_reg;
            b_wide_reg <= b_wide_next;
            b_sq_reg   <= 64'(a_prod_reg[0]) + 64'(a_prod_reg[1]) + 64'(a_prod_reg[2]);
            b_mag_reg  <= a_mag_reg;
            b_neg_reg  <= a_neg_reg;
        end
    end

    // Stage C: drop fraction bits, saturate, place results
    logic                 c_valid_reg;
    norm_side_t           c_side_reg;
    logic [63:0]          c_sq_reg;
    norm_side_t           c_side_next;
    logic [32:0]          sat_res [3];
    logic                 any_ov;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sat_res[i] = sat32(b_wide_reg[i] >>> FRAC_BITS);
        end
        any_ov = sat_res[0][32] | sat_res[1][32] | sat_res[2][32];
        c_side_next.res     = '0;
        c_side_next.is_norm = (b_mode_reg == MODE_NORM);
        c_side_next.neg     = b_neg_reg;
        c_side_next.mag     = b_mag_reg;
        unique case (b_mode_reg)
            MODE_ADD, MODE_SUB, MODE_SCALE, MODE_CROSS: begin
                c_side_next.res.r_x      = sat_res[0][31:0];
                c_side_next.res.r_y      = sat_res[1][31:0];
                c_side_next.res.r_z      = sat_res[2][31:0];
                c_side_next.res.overflow = any_ov;
            end
            MODE_DOT: begin
                c_side_next.res.dot_value = sat_res[0][31:0];
                c_side_next.res.overflow  = sat_res[0][32];
            end
            default: begin
                c_side_next.res = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_side_reg <= c_side_next;
            c_sq_reg   <= b_sq_reg;
        end
    end

    // Normalize pipeline; other operations ride through it
    logic n_valid;
    out_t n_res;

    v3a_norm #(
        .FRAC_BITS (FRAC_BITS)
    ) u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c_valid_reg),
        .in_sq     (c_sq_reg),
        .in_side   (c_side_reg),
        .out_valid (n_valid),
        .out_res   (n_res)
    );

    // Output register
    out_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= n_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= n_res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ design/v3a_checker.sv @@
// ----------------------------------------------------------------------------
// v3a_checker
// Port-level checks for the vector ALU, bound to the top level.
// ----------------------------------------------------------------------------
module v3a_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input v3a_pkg::in_t  s_data,
    input logic          m_valid,
    input logic          m_ready,
    input v3a_pkg::out_t m_data
);
    import v3a_pkg::*;

    // A stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // A stalled output stalls the whole pipe
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

    a_zero_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zero_length |-> m_data.r_x == 0 && m_data.r_y == 0 &&
            m_data.r_z == 0 && m_data.dot_value == 0 && !m_data.overflow)
        else $error("zero-length result carries data");

    a_dot_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.dot_value != 0 |-> m_data.r_x == 0 && m_data.r_y == 0 &&
            m_data.r_z == 0)
        else $error("dot result mixed with vector result");

endmodule

bind vec3_alu v3a_checker u_v3a_checker (.*);

@@ tb/vec3_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec3_checker
// Watches both channels of the vector ALU, works out the result of every
// accepted input word in fixed point and compares it with the output words.
// ----------------------------------------------------------------------------
module vec3_checker #(
    parameter int FRAC = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_ready,
    input  v3a_pkg::in_t   s_data,
    input  logic           m_valid,
    input  logic           m_ready,
    input  v3a_pkg::out_t  m_data,
    output int             fail_count,
    output int             pending
);
    import v3a_pkg::*;

    out_t expected_results[$];

    // clip a wide signed value to 32 bits, flagging when it does not fit
    function automatic logic signed [31:0] clip32(input logic signed [65:0] v,
                                                  inout logic ovf);
        if (v > 66'sd2147483647) begin
            ovf = 1'b1;
            return MAX32;
        end
        if (v < -66'sd2147483648) begin
            ovf = 1'b1;
            return MIN32;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] rbit;
        res  = '0;
        rbit = 64'd1 << 62;
        while (rbit > n) rbit = rbit >> 2;
        while (rbit != 0) begin
            if (n >= res + rbit) begin
                n   = n - (res + rbit);
                res = (res >> 1) + rbit;
            end else begin
                res = res >> 1;
            end
            rbit = rbit >> 2;
        end
        return res;
    endfunction

    function automatic out_t vector_result(input in_t w);
        out_t r;
        logic signed [65:0] t;
        logic signed [31:0] av [3];
        logic signed [31:0] bv [3];
        logic [31:0] mg [3];
        logic [63:0] sq;
        logic [63:0] root;
        logic [63:0] q;
        logic ovf;
        r   = '0;
        ovf = 1'b0;
        av  = '{w.a_x, w.a_y, w.a_z};
        bv  = '{w.b_x, w.b_y, w.b_z};
        case (w.mode)
            MODE_ADD, MODE_SUB, MODE_SCALE, MODE_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    if (w.mode == MODE_ADD) begin
                        t = av[i];
                        t = t + bv[i];
                    end else if (w.mode == MODE_SUB) begin
                        t = av[i];
                        t = t - bv[i];
                    end else if (w.mode == MODE_SCALE) begin
                        t = av[i] * w.scale_factor;
                        t = t >>> FRAC;
                    end else begin
                        t = av[(i+1)%3] * bv[(i+2)%3];
                        t = t - av[(i+2)%3] * bv[(i+1)%3];
                        t = t >>> FRAC;
                    end
                    if (i == 0) r.r_x = clip32(t, ovf);
                    else if (i == 1) r.r_y = clip32(t, ovf);
                    else r.r_z = clip32(t, ovf);
                end
            end
            MODE_DOT: begin
                t = av[0] * bv[0];
                t = t + av[1] * bv[1];
                t = t + av[2] * bv[2];
                t = t >>> FRAC;
                r.dot_value = clip32(t, ovf);
            end
            MODE_NORM: begin
                sq = '0;
                for (int i = 0; i < 3; i++) begin
                    mg[i] = bv[i][31] ? -bv[i] : bv[i];
                    sq = sq + 64'(mg[i]) * 64'(mg[i]);
                end
                root = root64(sq);
                if (root == 0) begin
                    r.zero_length = 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        q = (64'(mg[i]) << FRAC) / root;
                        if (bv[i][31]) q = -q;
                        if (i == 0) r.r_x = q[31:0];
                        else if (i == 1) r.r_y = q[31:0];
                        else r.r_z = q[31:0];
                    end
                end
            end
            default: ;
        endcase
        r.overflow = ovf;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch %s: expected %h got %h", name, exp_v, act_v);
        end
    endtask

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge aclk) begin
        out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) expected_results.push_back(vector_result(s_data));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected output word %h", m_data);
                end else begin
                    want = expected_results.pop_front();
                    check_field("r_x", want.r_x, m_data.r_x);
                    check_field("r_y", want.r_y, m_data.r_y);
                    check_field("r_z", want.r_z, m_data.r_z);
                    check_field("dot_value", want.dot_value, m_data.dot_value);
                    check_field("overflow", 32'(want.overflow), 32'(m_data.overflow));
                    check_field("zero_length", 32'(want.zero_length),
                                32'(m_data.zero_length));
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random vector operations into vec3_alu with bursty
// input and a stalling output; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    import v3a_pkg::*;

    localparam int RANDOM_WORDS = 1450;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 80;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;
    int   fail_count;
    int   pending;
    int   cycle_count;

    vec3_alu dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    vec3_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // receiver: phases of differing stall patterns, plus one long hold-off
    initial begin
        int mode_sel;
        int held;
        m_ready <= 1'b0;
        held = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            mode_sel = $urandom_range(0, 3);
            if (held == 0 && cycle_count > 1500) begin
                held = 1;
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
            end
            repeat ($urandom_range(20, 120)) begin
                case (mode_sel)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 1) == 1);
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (cycle_count % 3 != 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            3: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
            4: begin
                case ($urandom_range(0, 4))
                    0: return MAX32;
                    1: return MIN32;
                    2: return 32'sd0;
                    3: return -32'sd1;
                    default: return 32'sh0001_0000;
                endcase
            end
            default: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic in_t make_word(input logic [2:0] code,
                                      input logic signed [31:0] ax, ay, az,
                                      input logic signed [31:0] bx, by, bz,
                                      input logic signed [31:0] sf);
        in_t w;
        w.mode = mode_t'(code);
        w.a_x = ax; w.a_y = ay; w.a_z = az;
        w.b_x = bx; w.b_y = by; w.b_z = bz;
        w.scale_factor = sf;
        return w;
    endfunction

    // hold the word on the channel until it is taken
    task automatic send_word(input in_t w);
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    initial begin
        in_t directed[$];
        in_t w;
        int  sent;
        int  waited;
        s_valid <= 1'b0;
        s_data  <= '0;
        aresetn <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed.push_back(make_word(MODE_ADD, MAX32, MIN32, 1, MAX32, MIN32, -1, 0));
        directed.push_back(make_word(MODE_ADD, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_word(MODE_SUB, MIN32, MAX32, 0, MAX32, MIN32, MIN32, 0));
        directed.push_back(make_word(MODE_SUB, 5, -5, 7, 5, -5, -7, MAX32));
        directed.push_back(make_word(MODE_SCALE, MAX32, MIN32, -1, 0, 0, 0, MAX32));
        directed.push_back(make_word(MODE_SCALE, MIN32, MIN32, 3, 0, 0, 0, MIN32));
        directed.push_back(make_word(MODE_SCALE, 32'sh0002_8000, -32'sh0001_0000, -3,
                                     0, 0, 0, -1));
        directed.push_back(make_word(MODE_CROSS, 32'sh0001_0000, 0, 0, 0, 32'sh0001_0000,
                                     0, 0));
        directed.push_back(make_word(MODE_CROSS, MAX32, MIN32, MAX32, MIN32, MAX32, MIN32,
                                     0));
        directed.push_back(make_word(MODE_CROSS, MIN32, MIN32, MIN32, MAX32, MAX32, MAX32,
                                     0));
        directed.push_back(make_word(MODE_DOT, MIN32, MIN32, MIN32, MIN32, MIN32, MIN32, 0));
        directed.push_back(make_word(MODE_DOT, MAX32, MIN32, 1, MIN32, MAX32, -1, 0));
        directed.push_back(make_word(MODE_DOT, -1, 1, -1, 1, 1, 1, 0));
        directed.push_back(make_word(MODE_NORM, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_word(MODE_NORM, MAX32, 0, 0, MIN32, MIN32, MIN32, 0));
        directed.push_back(make_word(MODE_NORM, 0, 0, 0, MAX32, MAX32, MAX32, 0));
        directed.push_back(make_word(MODE_NORM, 0, 0, 0, 1, 0, 0, 0));
        directed.push_back(make_word(MODE_NORM, 0, 0, 0, -1, 1, -1, 0));
        directed.push_back(make_word(MODE_NORM, 0, 0, 0, 0, -32'sh0003_0000,
                                     32'sh0004_0000, 0));
        directed.push_back(make_word(3'd6, MAX32, MIN32, 1, -1, 5, 9, MAX32));
        directed.push_back(make_word(3'd7, -1, -1, -1, -1, -1, -1, -1));

        foreach (directed[i]) send_word(directed[i]);
        s_valid <= 1'b0;
        @(posedge aclk);

        sent = 0;
        while (sent < RANDOM_WORDS) begin
            repeat ($urandom_range(1, 40)) begin
                if (sent < RANDOM_WORDS) begin
                    w = make_word(($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                                 : 3'($urandom_range(0, 5)),
                                  pick_value(), pick_value(), pick_value(),
                                  pick_value(), pick_value(), pick_value(), pick_value());
                    send_word(w);
                    sent++;
                end
            end
            if ($urandom_range(0, 2) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 100000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/v3a_pkg.sv
design/v3a_norm.sv
design/vec3_alu.sv
design/v3a_checker.sv
tb/vec3_checker.sv
tb/tb_top.sv
